// File: src/dense_graph_shortest_path_top_macros.svh
// Assertion macros used by the checker
`ifndef DENSE_GRAPH_SHORTEST_PATH_TOP_MACROS_SVH
`define DENSE_GRAPH_SHORTEST_PATH_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define DGSP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dgsp assertion failed");

// Next-cycle implication, sampled on clk, off during reset
`define DGSP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dgsp assertion failed");

`endif

// File: src/dgsp_pkg.sv
package dgsp_pkg;

  // Request codes
  localparam logic [1:0] REQ_ADD_VERTEX = 2'd0;
  localparam logic [1:0] REQ_ADD_EDGE   = 2'd1;
  localparam logic [1:0] REQ_QUERY      = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_BAD_ID      = 2'd1;
  localparam logic [1:0] ST_UNREACHABLE = 2'd2;

  // Port field widths
  localparam int ID_W   = 6;
  localparam int LEN_W  = 16;
  localparam int PATH_W = 22;

  typedef enum logic [2:0] {
    S_IDLE,
    S_AV,
    S_AE1,
    S_AE2,
    S_RSTART,
    S_RELAX,
    S_DONE
  } state_t;

  // Control handed from the sequencer to every cell
  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

endpackage

// File: src/dgsp_req_if.sv
interface dgsp_req_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   req_type;
  logic [dgsp_pkg::ID_W-1:0]    vertex_a;
  logic [dgsp_pkg::ID_W-1:0]    vertex_b;
  logic [dgsp_pkg::LEN_W-1:0]   edge_length;

  modport source (output valid, req_type, vertex_a, vertex_b, edge_length, input ready);
  modport sink   (input valid, req_type, vertex_a, vertex_b, edge_length, output ready);
endinterface

// File: src/dgsp_rsp_if.sv
interface dgsp_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [dgsp_pkg::PATH_W-1:0]  path_length;
  logic [1:0]                   status;

  modport source (output valid, path_length, status, input ready);
  modport sink   (input valid, path_length, status, output ready);
endinterface

// File: src/dgsp_ram.sv
module dgsp_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: src/dgsp_cell.sv
module dgsp_cell #(
  parameter int DW = 22
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dgsp_pkg::cell_ctrl_t ctrl,
  input  logic                 set_src,
  input  logic                 nxt_reached,
  input  logic                 nxt_settled,
  input  logic [DW-1:0]        nxt_dist,
  output logic                 reached,
  output logic                 settled,
  output logic [DW-1:0]        tdist
);

  // Flags: clear at query start (reached set on the source), otherwise take the neighbour's on a shift
  always_ff @(posedge clk) begin
    if (rst) begin
      reached <= 1'b0;
      settled <= 1'b0;
    end else if (ctrl.clear) begin
      reached <= set_src;
      settled <= 1'b0;
    end else if (ctrl.shift) begin
      reached <= nxt_reached;
      settled <= nxt_settled;
    end
  end

  // Distance payload
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      tdist <= '0;
    end else if (ctrl.shift) begin
      tdist <= nxt_dist;
    end
  end

endmodule

// File: src/dense_graph_shortest_path_top.sv
// Add vertex writes the new row and column of the matrix, add edge writes
// both directions, a bad-id query goes straight to its answer and ignored
// requests are dropped; an answer waits out any output stall. Query: at
// most count rounds, one per settled vertex, each rotating the ring of cells
// once past one matrix read port; the answer is registered in DONE after them.
// One request in flight. Synchronous reset empties the graph and control state.
module dense_graph_shortest_path_top #(
  parameter int MAX_VERTICES = 64,
  parameter int EDGE_BITS    = 16
) (
  input logic clk,
  input logic rst,
  dgsp_req_if.sink   req,
  dgsp_rsp_if.source rsp
);

  localparam int IW   = $clog2(MAX_VERTICES);
  localparam int CW   = $clog2(MAX_VERTICES + 1);
  localparam int EW   = EDGE_BITS + 1;
  localparam int AW   = 2 * IW;
  localparam int DW   = EDGE_BITS + IW;
  localparam int CMPW = (CW > dgsp_pkg::ID_W) ? CW : dgsp_pkg::ID_W;
  localparam int XW   = (DW > dgsp_pkg::PATH_W) ? DW : dgsp_pkg::PATH_W;
  localparam logic [IW-1:0] LAST = IW'(MAX_VERTICES - 1);
  localparam logic [XW-1:0] PATH_SAT = XW'((64'd1 << dgsp_pkg::PATH_W) - 64'd1);

  dgsp_pkg::state_t state, state_next;

  logic [CW-1:0]          count;
  logic [IW-1:0]          ra, rb;
  logic [EDGE_BITS-1:0]   rw;
  logic [IW-1:0]          k;
  logic                   ph;
  logic [IW-1:0]          u;
  logic [DW-1:0]          best;
  logic                   mfound;
  logic [DW-1:0]          mbest;
  logic [IW-1:0]          mu;
  logic                   res_bad;
  logic                   dst_reached;
  logic [DW-1:0]          dst_dist;

  logic                   acc;
  logic                   a_ok, b_ok, full;
  logic                   ram_we;
  logic [AW-1:0]          ram_addr;
  logic [EW-1:0]          ram_wdata, ram_rdata;
  dgsp_pkg::cell_ctrl_t   cctl;

  logic                   cr [MAX_VERTICES];
  logic                   cs [MAX_VERTICES];
  logic [DW-1:0]          cd [MAX_VERTICES];

  logic                   k_ok, upd, cand, hn_r, hn_s;
  logic [DW-1:0]          nd, hn_d;
  logic                   mf_n;
  logic [DW-1:0]          mb_n;
  logic [IW-1:0]          mu_n;
  logic                   out_load;
  logic [1:0]             res_st;
  logic [XW-1:0]          dist_x;
  logic [dgsp_pkg::PATH_W-1:0] res_len;

  assign acc  = req.valid && req.ready;
  assign a_ok = CMPW'(req.vertex_a) < CMPW'(count);
  assign b_ok = CMPW'(req.vertex_b) < CMPW'(count);
  assign full = count == CW'(MAX_VERTICES);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      dgsp_pkg::S_IDLE: begin
        if (req.valid) begin
          case (req.req_type)
            dgsp_pkg::REQ_ADD_VERTEX: if (!full) state_next = dgsp_pkg::S_AV;
            dgsp_pkg::REQ_ADD_EDGE:   if (a_ok && b_ok) state_next = dgsp_pkg::S_AE1;
            dgsp_pkg::REQ_QUERY: begin
              state_next = (a_ok && b_ok) ? dgsp_pkg::S_RSTART : dgsp_pkg::S_DONE;
            end
            default: state_next = dgsp_pkg::S_IDLE;
          endcase
        end
      end
      dgsp_pkg::S_AV:     if (ph && k == IW'(count)) state_next = dgsp_pkg::S_IDLE;
      dgsp_pkg::S_AE1:    state_next = dgsp_pkg::S_AE2;
      dgsp_pkg::S_AE2:    state_next = dgsp_pkg::S_IDLE;
      dgsp_pkg::S_RSTART: state_next = dgsp_pkg::S_RELAX;
      dgsp_pkg::S_RELAX: begin
        if (k == LAST) state_next = mf_n ? dgsp_pkg::S_RSTART : dgsp_pkg::S_DONE;
      end
      dgsp_pkg::S_DONE:   if (!rsp.valid || rsp.ready) state_next = dgsp_pkg::S_IDLE;
      default:            state_next = dgsp_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    req.ready  = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = {u, k};
    ram_wdata  = '0;
    cctl.clear = 1'b0;
    cctl.shift = 1'b0;
    out_load   = 1'b0;
    case (state)
      dgsp_pkg::S_IDLE: begin
        req.ready  = 1'b1;
        cctl.clear = req.valid && req.req_type == dgsp_pkg::REQ_QUERY && a_ok && b_ok;
      end
      dgsp_pkg::S_AV: begin
        ram_we    = 1'b1;
        ram_addr  = ph ? {k, IW'(count)} : {IW'(count), k};
        ram_wdata = (ph && k == IW'(count)) ? EW'(0) : EW'(1) << EDGE_BITS;
      end
      dgsp_pkg::S_AE1: begin
        ram_we    = 1'b1;
        ram_addr  = {ra, rb};
        ram_wdata = {1'b0, rw};
      end
      dgsp_pkg::S_AE2: begin
        ram_we    = 1'b1;
        ram_addr  = {rb, ra};
        ram_wdata = {1'b0, rw};
      end
      dgsp_pkg::S_RSTART: ram_addr = {u, IW'(0)};
      dgsp_pkg::S_RELAX: begin
        ram_addr   = {u, k + IW'(1)};
        cctl.shift = 1'b1;
      end
      dgsp_pkg::S_DONE: out_load = !rsp.valid || rsp.ready;
      default: ;
    endcase
  end

  dgsp_ram #(.WIDTH(EW), .DEPTH(1 << AW)) u_matrix (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Relaxation at the head of the ring, and running minimum for next round
  always_comb begin
    k_ok = CW'(k) < count;
    nd   = best + DW'(ram_rdata[EDGE_BITS-1:0]);
    upd  = k_ok && !ram_rdata[EDGE_BITS] && (!cr[0] || nd < cd[0]);
    hn_r = cr[0] || upd;
    hn_d = upd ? nd : cd[0];
    hn_s = cs[0] || (k_ok && k == u);
    cand = k_ok && hn_r && !hn_s && (!mfound || hn_d < mbest);
    mf_n = mfound || cand;
    mb_n = cand ? hn_d : mbest;
    mu_n = cand ? k : mu;
  end

  // Ring of cells, cell 0 at the head
  for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
    if (i == MAX_VERTICES - 1) begin : g_tail
      dgsp_cell #(.DW(DW)) u_cell (
        .clk (clk), .rst (rst), .ctrl (cctl),
        .set_src (IW'(req.vertex_a) == IW'(i)),
        .nxt_reached (hn_r), .nxt_settled (hn_s), .nxt_dist (hn_d),
        .reached (cr[i]), .settled (cs[i]), .tdist (cd[i])
      );
    end else begin : g_mid
      dgsp_cell #(.DW(DW)) u_cell (
        .clk (clk), .rst (rst), .ctrl (cctl),
        .set_src (IW'(req.vertex_a) == IW'(i)),
        .nxt_reached (cr[i+1]), .nxt_settled (cs[i+1]), .nxt_dist (cd[i+1]),
        .reached (cr[i]), .settled (cs[i]), .tdist (cd[i])
      );
    end
  end

  // Result of a finished query, with saturation
  always_comb begin
    dist_x  = XW'(dst_dist);
    res_len = '0;
    if (res_bad) begin
      res_st = dgsp_pkg::ST_BAD_ID;
    end else if (!dst_reached) begin
      res_st = dgsp_pkg::ST_UNREACHABLE;
    end else begin
      res_st  = dgsp_pkg::ST_OK;
      res_len = (dist_x > PATH_SAT) ? '1 : dist_x[dgsp_pkg::PATH_W-1:0];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dgsp_pkg::S_IDLE;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == dgsp_pkg::S_AV && state_next == dgsp_pkg::S_IDLE) count <= count + CW'(1);
      if (out_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (acc) begin
      ra      <= IW'(req.vertex_a);
      rb      <= IW'(req.vertex_b);
      rw      <= EDGE_BITS'(req.edge_length);
      u       <= IW'(req.vertex_a);
      best    <= '0;
      res_bad <= !(a_ok && b_ok);
      k       <= '0;
      ph      <= 1'b0;
    end
    case (state)
      dgsp_pkg::S_AV: begin
        ph <= !ph;
        if (ph) k <= k + IW'(1);
      end
      dgsp_pkg::S_RSTART: begin
        k      <= '0;
        mfound <= 1'b0;
        mbest  <= '0;
        mu     <= '0;
      end
      dgsp_pkg::S_RELAX: begin
        k      <= k + IW'(1);
        mfound <= mf_n;
        mbest  <= mb_n;
        mu     <= mu_n;
        // destination's entry as it leaves the head; final after the last round
        if (k == rb) begin
          dst_reached <= hn_r;
          dst_dist    <= hn_d;
        end
        if (k == LAST) begin
          u    <= mu_n;
          best <= mb_n;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      rsp.path_length <= res_len;
      rsp.status      <= res_st;
    end
  end

endmodule

// File: src/dgsp_checker.sv
`include "dense_graph_shortest_path_top_macros.svh"

module dgsp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [21:0] path_length,
  input logic [1:0]  status
);

  `DGSP_ASSERT_NXT(a_hold_valid, out_valid && !out_ready, out_valid)
  `DGSP_ASSERT_NXT(a_hold_len, out_valid && !out_ready, $stable(path_length))
  `DGSP_ASSERT_IMP(a_status_code, out_valid, status <= dgsp_pkg::ST_UNREACHABLE)
  `DGSP_ASSERT_IMP(a_zero_on_fail, out_valid && status != dgsp_pkg::ST_OK, path_length == '0)

endmodule

bind dense_graph_shortest_path_top dgsp_checker u_dgsp_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (rsp.valid),
  .out_ready   (rsp.ready),
  .path_length (rsp.path_length),
  .status      (rsp.status)
);

// File: dv/testbench.sv
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NV         = 64;
  localparam int WB         = 16;
  localparam int N_RANDOM   = 120;
  localparam int HOLD_CYC   = 6000;
  localparam int DRAIN_CYC  = 4500;

  // Path scoreboard: mirrors the graph and keeps expected query answers
  class path_scoreboard;
    logic [WB:0]                  dist_mat [NV][NV];
    int                           n_vert;
    logic [dgsp_pkg::PATH_W+1:0]  answers [$];
    int                           n_err;
    int                           n_ok, n_bad, n_unreach;

    function new();
      n_vert = 0;
      n_err  = 0;
      n_ok = 0; n_bad = 0; n_unreach = 0;
    endfunction

    // Shortest path by linear minimum search over unsettled vertices
    function void solve_path(int src, int dst, output logic [dgsp_pkg::PATH_W-1:0] len,
                             output logic [1:0] st);
      longint d [NV];
      bit     seen [NV];
      bit     done [NV];
      longint best, nd;
      int     u;
      bit     found;
      if (src >= n_vert || dst >= n_vert) begin
        len = '0;
        st  = dgsp_pkg::ST_BAD_ID;
        return;
      end
      foreach (d[i]) begin
        d[i] = 0; seen[i] = 0; done[i] = 0;
      end
      seen[src] = 1;
      for (int r = 0; r < n_vert; r++) begin
        found = 0; u = 0; best = 0;
        for (int i = 0; i < n_vert; i++)
          if (seen[i] && !done[i] && (!found || d[i] < best)) begin
            found = 1; u = i; best = d[i];
          end
        if (!found) break;
        done[u] = 1;
        for (int i = 0; i < n_vert; i++) begin
          if (dist_mat[u][i][WB]) continue;
          nd = best + dist_mat[u][i][WB-1:0];
          if (!seen[i] || nd < d[i]) begin
            seen[i] = 1; d[i] = nd;
          end
        end
      end
      if (!seen[dst]) begin
        len = '0;
        st  = dgsp_pkg::ST_UNREACHABLE;
      end else begin
        len = (d[dst] > 64'h3FFFFF) ? '1 : d[dst][dgsp_pkg::PATH_W-1:0];
        st  = dgsp_pkg::ST_OK;
      end
    endfunction

    // Note an accepted request and update the mirrored graph
    function void note_request(logic [1:0] kind, logic [dgsp_pkg::ID_W-1:0] a,
                               logic [dgsp_pkg::ID_W-1:0] b,
                               logic [dgsp_pkg::LEN_W-1:0] w);
      logic [dgsp_pkg::PATH_W-1:0] len;
      logic [1:0]                  st;
      case (kind)
        dgsp_pkg::REQ_ADD_VERTEX: begin
          if (n_vert < NV) begin
            for (int i = 0; i <= n_vert; i++) begin
              dist_mat[n_vert][i] = {1'b1, {WB{1'b0}}};
              dist_mat[i][n_vert] = {1'b1, {WB{1'b0}}};
            end
            dist_mat[n_vert][n_vert] = '0;
            n_vert++;
          end
        end
        dgsp_pkg::REQ_ADD_EDGE: begin
          if (a < n_vert && b < n_vert) begin
            dist_mat[a][b] = {1'b0, w[WB-1:0]};
            dist_mat[b][a] = {1'b0, w[WB-1:0]};
          end
        end
        dgsp_pkg::REQ_QUERY: begin
          solve_path(a, b, len, st);
          answers.push_back({st, len});
          case (st)
            dgsp_pkg::ST_OK:     n_ok++;
            dgsp_pkg::ST_BAD_ID: n_bad++;
            default:             n_unreach++;
          endcase
        end
        default: ;
      endcase
    endfunction

    // Compare a delivered answer with the oldest outstanding one
    function void check_answer(logic [dgsp_pkg::PATH_W-1:0] len, logic [1:0] st);
      logic [dgsp_pkg::PATH_W+1:0] exp_word;
      if (answers.size() == 0) begin
        $error("unexpected answer: path_length=%0d status=%0d", len, st);
        n_err++;
        return;
      end
      exp_word = answers.pop_front();
      if (st !== exp_word[dgsp_pkg::PATH_W+1:dgsp_pkg::PATH_W]) begin
        $error("status: expected %0d, got %0d",
               exp_word[dgsp_pkg::PATH_W+1:dgsp_pkg::PATH_W], st);
        n_err++;
      end
      if (len !== exp_word[dgsp_pkg::PATH_W-1:0]) begin
        $error("path_length: expected %0d, got %0d", exp_word[dgsp_pkg::PATH_W-1:0], len);
        n_err++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  dgsp_req_if req_if ();
  dgsp_rsp_if rsp_if ();

  dense_graph_shortest_path_top u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if.sink),
    .rsp (rsp_if.source)
  );

  path_scoreboard sb = new();
  bit             stim_done = 0;
  int             n_answers = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Offer one request after a random gap, hold it until transferred
  task automatic send_request(logic [1:0] kind, logic [dgsp_pkg::ID_W-1:0] a,
                              logic [dgsp_pkg::ID_W-1:0] b,
                              logic [dgsp_pkg::LEN_W-1:0] w);
    int gap;
    gap = $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    @(negedge clk);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.req_type    <= kind;
    req_if.vertex_a    <= a;
    req_if.vertex_b    <= b;
    req_if.edge_length <= w;
    do @(posedge clk); while (!req_if.ready);
    sb.note_request(kind, a, b, w);
  endtask

  // Random request, weighted towards well-formed graph building
  task automatic send_random();
    int                         r;
    logic [1:0]                 kind;
    logic [dgsp_pkg::ID_W-1:0]  a, b;
    logic [dgsp_pkg::LEN_W-1:0] w;
    r = $urandom_range(0, 99);
    if (r < 38)      kind = dgsp_pkg::REQ_ADD_VERTEX;
    else if (r < 66) kind = dgsp_pkg::REQ_ADD_EDGE;
    else if (r < 95) kind = dgsp_pkg::REQ_QUERY;
    else             kind = 2'd3;
    if (sb.n_vert > 0 && $urandom_range(0, 7) != 0) begin
      a = $urandom_range(0, sb.n_vert - 1);
      b = $urandom_range(0, sb.n_vert - 1);
    end else begin
      a = $urandom_range(0, 63);
      b = $urandom_range(0, 63);
    end
    case ($urandom_range(0, 7))
      0:       w = '0;
      1:       w = '1;
      2, 3:    w = $urandom_range(0, 15);
      default: w = $urandom_range(0, 65535);
    endcase
    send_request(kind, a, b, w);
  endtask

  // Receiver: random stalls, plus one long hold-off to back up the block
  initial begin
    int gap;
    rsp_if.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = $urandom_range(0, 13);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (n_answers == 12) gap = HOLD_CYC;
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
      sb.check_answer(rsp_if.path_length, rsp_if.status);
      n_answers++;
      @(negedge clk);
    end
  end

  // Main stimulus
  initial begin
    req_if.valid       = 1'b0;
    req_if.req_type    = dgsp_pkg::REQ_ADD_VERTEX;
    req_if.vertex_a    = '0;
    req_if.vertex_b    = '0;
    req_if.edge_length = '0;
    rst = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty graph, extremes, self loop, bad ids, unused code
    send_request(dgsp_pkg::REQ_QUERY, 0, 0, 0);
    send_request(dgsp_pkg::REQ_ADD_VERTEX, 0, 0, 0);
    send_request(dgsp_pkg::REQ_ADD_VERTEX, 0, 0, 0);
    send_request(dgsp_pkg::REQ_ADD_VERTEX, 0, 0, 0);
    send_request(dgsp_pkg::REQ_QUERY, 0, 2, 0);
    send_request(dgsp_pkg::REQ_ADD_EDGE, 0, 1, 16'h0000);
    send_request(dgsp_pkg::REQ_ADD_EDGE, 1, 2, 16'hFFFF);
    send_request(dgsp_pkg::REQ_QUERY, 0, 2, 0);
    send_request(dgsp_pkg::REQ_ADD_EDGE, 2, 0, 5);
    send_request(dgsp_pkg::REQ_QUERY, 2, 0, 0);
    send_request(dgsp_pkg::REQ_ADD_EDGE, 1, 1, 7);
    send_request(dgsp_pkg::REQ_QUERY, 1, 1, 0);
    send_request(dgsp_pkg::REQ_ADD_EDGE, 0, 5, 9);
    send_request(2'd3, 6'h3F, 6'h3F, 16'hFFFF);
    send_request(dgsp_pkg::REQ_QUERY, 0, 3, 0);
    send_request(dgsp_pkg::REQ_QUERY, 6'h3F, 0, 0);
    send_request(dgsp_pkg::REQ_ADD_EDGE, 0, 1, 16'hFFFF);
    send_request(dgsp_pkg::REQ_ADD_VERTEX, 0, 0, 0);
    send_request(dgsp_pkg::REQ_ADD_EDGE, 3, 6'h3F, 1);
    send_request(dgsp_pkg::REQ_QUERY, 3, 0, 0);
    send_request(dgsp_pkg::REQ_QUERY, 2, 1, 0);

    // Random part
    for (int k = 0; k < N_RANDOM; k++) send_random();
    @(negedge clk);
    req_if.valid <= 1'b0;

    while (sb.answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    $display("Covered %0d answers (%0d ok, %0d bad id, %0d unreachable), %0d vertices.",
             n_answers, sb.n_ok, sb.n_bad, sb.n_unreach, sb.n_vert);
    if (sb.n_err == 0 && sb.answers.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
